// ===== src/ste_pkg.sv =====
// Shared types and constants for the sleep timer wake table.
package ste_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned TICK_W   = 40;
  localparam int unsigned FEMTO_W  = 54;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SEC_W    = 14;
  localparam int unsigned NSEC_W   = 30;

  localparam logic [TICK_W-1:0] FEMTO_PER_SEC  = 40'd1000000000000;
  localparam logic [9:0]        FEMTO_PER_NSEC = 10'd1000;
  localparam logic [TICK_W-1:0] TICK_RESET     = FEMTO_PER_SEC;

  typedef enum logic [1:0] {
    CMD_SLEEP = 2'd0,
    CMD_WAIT  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_WAKE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ACCEPTED = 2'd0,
    STAT_WOKEN    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NONE     = 2'd3
  } status_e;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic                timed;
    logic [HANDLE_W-1:0] thread;
    logic [HANDLE_W-1:0] key;
    logic [FEMTO_W-1:0]  target;
    logic [FEMTO_W-1:0]  elapsed;
  } slot_t;

endpackage

// ===== src/sleep_timer_wake_table.sv =====
// Top level of the sleep timer wake table: command sequencer over a slot memory.
//
// Requests enter on the s_ channel (tuser = command, tdata = thread handle, key,
// seconds, nanoseconds). Each request yields one or more results on the m_
// channel (tuser = status, tdata = woken thread, woken key, timer active);
// tlast marks the final result of a request. tick_femtos is written through
// cfg_we_i / cfg_wdata_i, at an edge only while the block is idle: the user
// keeps to this, the block does not enforce it. Entries live compacted in
// arrival order in one slot memory (one write and one registered read port).
// A sleep or wait goes from acceptance to its result through the accept,
// multiply, store and answer steps. A tick or wake sweeps the occupied slots
// at one slot per cycle while the output register is free, reading slot i+1
// through the single read port while slot i is rewritten at its compacted
// place. A tick that finds no timed entry, a wake on an empty table, or a
// sleep or wait on a full table answers straight from acceptance.
// A woken entry is held one step so that tlast can be set on the final one;
// when the receiver stalls, the sweep holds in place until the output
// register frees up. A new request is taken while a result still waits.
// Reset empties the table, stops the timer and sets tick_femtos to 1e12;
// only slots below the fill count are ever read, so memory needs no clearing.
module sleep_timer_wake_table #(
  parameter int unsigned SLOTS = ste_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,  // thread_handle[15:0], key[31:16], duration_sec[45:32],
                                  // duration_nsec[75:46], zero pad[79:76]
  input  logic [1:0]  s_tuser_i,  // command[1:0]
  // result channel
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,  // woken_thread[15:0], woken_key[31:16],
                                  // timer_active[32], zero pad[39:33]
  output logic [1:0]  m_tuser_o,  // status[1:0]
  output logic        m_tlast_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i  // tick_femtos
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned NW = $clog2(ste_pkg::MAX_RESULTS + 1);
  localparam int unsigned FW = ste_pkg::FEMTO_W;
  localparam int unsigned HW = ste_pkg::HANDLE_W;
  localparam int unsigned EW = $bits(ste_pkg::slot_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STORE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                       state_q;
  ste_pkg::cmd_e                cmd_q;
  logic [HW-1:0]                thr_q;
  logic [HW-1:0]                key_q;
  logic [ste_pkg::SEC_W-1:0]    sec_q;
  logic [ste_pkg::NSEC_W-1:0]   nsec_q;
  logic [FW-1:0]                prod_sec_q;
  logic [ste_pkg::TICK_W-1:0]   prod_nsec_q;
  logic [CW-1:0]                cnt_q;        // fill count
  logic [CW-1:0]                timed_cnt_q;  // timed entries in the table
  logic                         timer_on_q;
  logic [ste_pkg::TICK_W-1:0]   tick_q;
  logic [IW-1:0]                idx_q;        // slot whose word sits on the read port
  logic [CW-1:0]                wr_q;         // compacted write place
  logic [NW-1:0]                n_q;          // wakes so far in this request
  logic                         pend_q;
  logic [HW-1:0]                pend_thr_q;
  logic [HW-1:0]                pend_key_q;
  ste_pkg::status_e             fin_status_q;
  logic                         out_valid_q;
  ste_pkg::status_e             out_status_q;
  logic [HW-1:0]                out_thr_q;
  logic [HW-1:0]                out_key_q;
  logic                         out_timer_q;
  logic                         out_last_q;

  logic                         in_acc;
  ste_pkg::cmd_e                in_cmd;
  logic                         out_free;
  logic                         out_load;
  logic [EW-1:0]                rd_word;
  ste_pkg::slot_t               rd_entry;
  ste_pkg::slot_t               keep_entry;
  ste_pkg::slot_t               new_entry;
  logic [FW:0]                  sum_elapsed;
  logic                         time_up;
  logic                         room;
  logic                         hit;
  logic                         scan_stall;
  logic                         scan_go;
  logic                         scan_end;
  logic [FW-1:0]                store_target;
  logic                         store_timed;
  logic                         start_scan;
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic                         ram_re;
  logic [IW-1:0]                ram_raddr;

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign in_cmd     = ste_pkg::cmd_e'(s_tuser_i);
  assign out_free   = !out_valid_q || m_tready_i;

  // Sweep step: update the elapsed count and decide whether the slot wakes.
  assign rd_entry    = ste_pkg::slot_t'(rd_word);
  assign sum_elapsed = {1'b0, rd_entry.elapsed} + (FW + 1)'(tick_q);
  assign time_up     = sum_elapsed >= {1'b0, rd_entry.target};
  assign room        = n_q < NW'(ste_pkg::MAX_RESULTS);

  always_comb begin
    keep_entry = rd_entry;
    if (cmd_q == ste_pkg::CMD_TICK) begin
      hit = rd_entry.timed && time_up && room;
      if (rd_entry.timed) begin
        keep_entry.elapsed = time_up ? rd_entry.target : sum_elapsed[FW-1:0];
      end
    end else begin
      hit = !rd_entry.timed && (rd_entry.key == key_q) && room;
    end
  end

  assign scan_stall = (state_q == ST_SCAN) && hit && pend_q && !out_free;
  assign scan_go    = (state_q == ST_SCAN) && !scan_stall;
  assign scan_end   = ((CW'(idx_q) + CW'(1)) == cnt_q);

  // Output register loads either a released wake or the final result.
  assign out_load = (scan_go && hit && pend_q) || ((state_q == ST_DONE) && out_free);

  // New entry for a sleep or wait.
  assign store_target = prod_sec_q + FW'(prod_nsec_q);
  assign store_timed  = (store_target != '0);

  always_comb begin
    new_entry.timed   = store_timed;
    new_entry.thread  = thr_q;
    new_entry.key     = (cmd_q == ste_pkg::CMD_WAIT) ? key_q : (store_timed ? '0 : thr_q);
    new_entry.target  = store_target;
    new_entry.elapsed = '0;
  end

  assign start_scan = in_acc &&
                      (((in_cmd == ste_pkg::CMD_TICK) && (timed_cnt_q != '0)) ||
                       ((in_cmd == ste_pkg::CMD_WAKE) && (cnt_q != '0)));

  // Memory port control: read ahead one slot, write kept slots at their
  // compacted place (never above the slot being read).
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (start_scan) begin
      ram_re = 1'b1;
    end else if (scan_go && !scan_end) begin
      ram_re    = 1'b1;
      ram_raddr = idx_q + IW'(1);
    end
    ram_we    = 1'b0;
    ram_waddr = wr_q[IW-1:0];
    ram_wdata = keep_entry;
    if (state_q == ST_STORE) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[IW-1:0];
      ram_wdata = new_entry;
    end else if (scan_go && !hit) begin
      ram_we = 1'b1;
    end
  end

  ste_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= ste_pkg::CMD_SLEEP;
      thr_q        <= '0;
      key_q        <= '0;
      sec_q        <= '0;
      nsec_q       <= '0;
      prod_sec_q   <= '0;
      prod_nsec_q  <= '0;
      cnt_q        <= '0;
      timed_cnt_q  <= '0;
      timer_on_q   <= 1'b0;
      tick_q       <= ste_pkg::TICK_RESET;
      idx_q        <= '0;
      wr_q         <= '0;
      n_q          <= '0;
      pend_q       <= 1'b0;
      pend_thr_q   <= '0;
      pend_key_q   <= '0;
      fin_status_q <= ste_pkg::STAT_NONE;
      out_valid_q  <= 1'b0;
      out_status_q <= ste_pkg::STAT_NONE;
      out_thr_q    <= '0;
      out_key_q    <= '0;
      out_timer_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      // drop a result once taken unless a new one loads below
      if (out_valid_q && m_tready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_q        <= in_cmd;
            thr_q        <= s_tdata_i[15:0];
            key_q        <= s_tdata_i[31:16];
            sec_q        <= s_tdata_i[45:32];
            nsec_q       <= s_tdata_i[75:46];
            idx_q        <= '0;
            wr_q         <= '0;
            n_q          <= '0;
            pend_q       <= 1'b0;
            fin_status_q <= ste_pkg::STAT_NONE;
            case (in_cmd)
              ste_pkg::CMD_SLEEP, ste_pkg::CMD_WAIT: begin
                if (cnt_q == CW'(SLOTS)) begin
                  fin_status_q <= ste_pkg::STAT_FULL;
                  state_q      <= ST_DONE;
                end else begin
                  state_q <= ST_MUL;
                end
              end
              ste_pkg::CMD_TICK: begin
                if (timed_cnt_q == '0) begin
                  timer_on_q <= 1'b0;
                  state_q    <= ST_DONE;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              ste_pkg::CMD_WAKE: begin
                state_q <= (cnt_q == '0) ? ST_DONE : ST_SCAN;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        ST_MUL: begin
          if (cmd_q == ste_pkg::CMD_SLEEP) begin
            prod_sec_q  <= FW'(sec_q) * FW'(ste_pkg::FEMTO_PER_SEC);
            prod_nsec_q <= ste_pkg::TICK_W'(nsec_q) * ste_pkg::TICK_W'(ste_pkg::FEMTO_PER_NSEC);
          end else begin
            prod_sec_q  <= '0;
            prod_nsec_q <= '0;
          end
          state_q <= ST_STORE;
        end

        ST_STORE: begin
          cnt_q <= cnt_q + CW'(1);
          if (store_timed) begin
            timer_on_q  <= 1'b1;
            timed_cnt_q <= timed_cnt_q + CW'(1);
          end
          fin_status_q <= ste_pkg::STAT_ACCEPTED;
          state_q      <= ST_DONE;
        end

        ST_SCAN: begin
          if (scan_go) begin
            if (hit) begin
              // release the held wake, hold this one so tlast can follow
              if (pend_q) begin
                out_valid_q  <= 1'b1;
                out_status_q <= ste_pkg::STAT_WOKEN;
                out_thr_q    <= pend_thr_q;
                out_key_q    <= pend_key_q;
                out_timer_q  <= timer_on_q;
                out_last_q   <= 1'b0;
              end
              pend_q     <= 1'b1;
              pend_thr_q <= rd_entry.thread;
              pend_key_q <= rd_entry.timed ? '0 : rd_entry.key;
              n_q        <= n_q + NW'(1);
              if (rd_entry.timed) begin
                timed_cnt_q <= timed_cnt_q - CW'(1);
              end
            end else begin
              wr_q <= wr_q + CW'(1);
            end
            if (scan_end) begin
              cnt_q   <= hit ? wr_q : (wr_q + CW'(1));
              state_q <= ST_DONE;
            end else begin
              idx_q <= idx_q + IW'(1);
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= pend_q ? ste_pkg::STAT_WOKEN : fin_status_q;
            out_thr_q    <= pend_q ? pend_thr_q : '0;
            out_key_q    <= pend_q ? pend_key_q : '0;
            out_timer_q  <= timer_on_q;
            out_last_q   <= 1'b1;
            pend_q       <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {7'b0, out_timer_q, out_key_q, out_thr_q};
  assign m_tlast_o  = out_last_q;

  // The fill count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("fill count above table size");

  // Timed entries are a subset of the stored entries.
  a_timed_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timed_cnt_q <= cnt_q)
    else $error("timed count above fill count");

  // A stored timed entry keeps the tick source enabled.
  a_timer_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timed_cnt_q != '0) |-> timer_on_q)
    else $error("timed entry present with timer off");

  // Compaction writes never overtake the read sweep.
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (wr_q <= CW'(idx_q)))
    else $error("compaction write ahead of read");

endmodule

// ===== src/ste_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ste_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sleep timer wake table: directed table plus random traffic.
module tb_top;

  localparam int unsigned TBL_SLOTS = ste_pkg::SLOTS_DEF;
  // Allow a good margin for a sweep in flight to finish before a config write.
  localparam int unsigned SETTLE_CYCLES = 2 * (TBL_SLOTS + 2) + 4;

  // One result as it leaves the block.
  typedef struct packed {
    ste_pkg::status_e status;
    logic [15:0]      thread;
    logic [15:0]      key;
    logic             timer_active;
    logic             last;
  } wake_result_t;

  // One sleeper held by the predictor, kept in arrival order.
  typedef struct packed {
    logic                        timed;
    logic [15:0]                 thread;
    logic [15:0]                 key;
    logic [ste_pkg::FEMTO_W-1:0] target;
    logic [ste_pkg::FEMTO_W-1:0] elapsed;
  } sleeper_t;

  // One row of the directed part; want holds a typed-in result when typed is set.
  typedef struct {
    ste_pkg::cmd_e cmd;
    logic [15:0]   thread;
    logic [15:0]   key;
    logic [13:0]   sec;
    logic [29:0]   nsec;
    int            reps;
    bit            typed;
    wake_result_t  want;
  } step_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [79:0] s_tdata_i = '0;
  logic [1:0]  s_tuser_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        m_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [39:0] cfg_wdata_i = '0;

  sleep_timer_wake_table #(.SLOTS(TBL_SLOTS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the sleeper table, the timer enable and the tick length.
  sleeper_t     sleepers[$];
  logic         timer_run = 1'b0;
  logic [39:0]  tick_len = ste_pkg::TICK_RESET;

  wake_result_t step_results[$];   // results of the request being predicted
  wake_result_t pending_wakes[$];  // results still owed by the block, oldest first
  step_row_t    dir_rows[$];

  int  fail_count = 0;
  bit  no_idle = 1'b0;             // set for stretches without any gaps

  // Return an idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic wake_result_t mk_result(ste_pkg::status_e st, logic [15:0] thr,
                                             logic [15:0] ky, logic ta);
    wake_result_t r;
    r.status       = st;
    r.thread       = thr;
    r.key          = ky;
    r.timer_active = ta;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic step_row_t row(ste_pkg::cmd_e cmd, logic [15:0] thr, logic [15:0] ky,
                                    logic [13:0] sec, logic [29:0] nsec, int reps, bit typed,
                                    ste_pkg::status_e st, logic [15:0] wthr,
                                    logic [15:0] wkey, logic ta);
    step_row_t r;
    r.cmd    = cmd;
    r.thread = thr;
    r.key    = ky;
    r.sec    = sec;
    r.nsec   = nsec;
    r.reps   = reps;
    r.typed  = typed;
    r.want   = mk_result(st, wthr, wkey, ta);
    return r;
  endfunction

  // Compute the results of one request and advance the sleeper table.
  task automatic predict_wakes(input ste_pkg::cmd_e cmd, input logic [15:0] thr,
                               input logic [15:0] ky, input logic [13:0] sec,
                               input logic [29:0] nsec);
    sleeper_t    ent;
    logic [63:0] target;
    logic [63:0] sum;
    bit          any_timed;
    int          i;
    step_results = {};
    case (cmd)
      ste_pkg::CMD_SLEEP, ste_pkg::CMD_WAIT: begin
        if (sleepers.size() >= TBL_SLOTS) begin
          step_results.push_back(mk_result(ste_pkg::STAT_FULL, '0, '0, 1'b0));
        end else begin
          target    = 64'd0;
          ent.timed = 1'b0;
          ent.key   = ky;
          if (cmd == ste_pkg::CMD_SLEEP) begin
            target = 64'(sec) * 64'(ste_pkg::FEMTO_PER_SEC) +
                     64'(nsec) * 64'(ste_pkg::FEMTO_PER_NSEC);
            // A zero-length sleep turns into a wait keyed by the thread handle.
            ent.timed = (target != 64'd0);
            ent.key   = ent.timed ? 16'd0 : thr;
          end
          ent.thread  = thr;
          ent.target  = target[ste_pkg::FEMTO_W-1:0];
          ent.elapsed = '0;
          sleepers.push_back(ent);
          if (ent.timed) timer_run = 1'b1;
          step_results.push_back(mk_result(ste_pkg::STAT_ACCEPTED, '0, '0, 1'b0));
        end
      end
      ste_pkg::CMD_TICK: begin
        any_timed = 1'b0;
        foreach (sleepers[j]) if (sleepers[j].timed) any_timed = 1'b1;
        // Only a tick that finds no timed entry stops the timer.
        if (!any_timed) begin
          timer_run = 1'b0;
        end else begin
          i = 0;
          while (i < sleepers.size()) begin
            if (sleepers[i].timed) begin
              sum = 64'(sleepers[i].elapsed) + 64'(tick_len);
              if (sum >= 64'(sleepers[i].target)) begin
                sleepers[i].elapsed = sleepers[i].target;
                if (step_results.size() < ste_pkg::MAX_RESULTS) begin
                  step_results.push_back(mk_result(ste_pkg::STAT_WOKEN, sleepers[i].thread,
                                                   '0, 1'b0));
                  sleepers.delete(i);
                  continue;
                end
              end else begin
                sleepers[i].elapsed = sum[ste_pkg::FEMTO_W-1:0];
              end
            end
            i++;
          end
        end
      end
      default: begin
        i = 0;
        while (i < sleepers.size()) begin
          if (!sleepers[i].timed && sleepers[i].key == ky &&
              step_results.size() < ste_pkg::MAX_RESULTS) begin
            step_results.push_back(mk_result(ste_pkg::STAT_WOKEN, sleepers[i].thread,
                                             sleepers[i].key, 1'b0));
            sleepers.delete(i);
            continue;
          end
          i++;
        end
      end
    endcase
    if (step_results.size() == 0)
      step_results.push_back(mk_result(ste_pkg::STAT_NONE, '0, '0, 1'b0));
    foreach (step_results[k]) begin
      step_results[k].timer_active = timer_run;
      step_results[k].last         = (k == step_results.size() - 1);
    end
  endtask

  // Drive one request, hold it until accepted, then queue what it must produce.
  task automatic push_request(input ste_pkg::cmd_e cmd, input logic [15:0] thr,
                              input logic [15:0] ky, input logic [13:0] sec,
                              input logic [29:0] nsec, input bit typed,
                              input wake_result_t want);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= {4'b0, nsec, sec, ky, thr};
    do @(posedge clk_i); while (!s_tready_o);
    predict_wakes(cmd, thr, ky, sec, nsec);
    if (typed) pending_wakes.push_back(want);
    else foreach (step_results[k]) pending_wakes.push_back(step_results[k]);
  endtask

  // Drop valid, wait for every owed result, then let any sweep in flight finish.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (pending_wakes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_tick(input logic [39:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tick_len = value;
  endtask

  // Random traffic: keys from a small pool so wakes hit, short sleeps so ticks wake them.
  task automatic run_random(input int count);
    ste_pkg::cmd_e cmd;
    logic [15:0]   thr;
    logic [15:0]   ky;
    logic [13:0]   sec;
    logic [29:0]   nsec;
    int            r;
    int            j;
    int            lim_sleep;
    int            lim_wait;
    int            lim_tick;
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      // Lean on ticks and wakes when the table runs close to full.
      if (sleepers.size() >= TBL_SLOTS - 3) begin
        lim_sleep = 15;
        lim_wait  = 30;
        lim_tick  = 70;
      end else begin
        lim_sleep = 35;
        lim_wait  = 60;
        lim_tick  = 82;
      end
      if (r < lim_sleep)     cmd = ste_pkg::CMD_SLEEP;
      else if (r < lim_wait) cmd = ste_pkg::CMD_WAIT;
      else if (r < lim_tick) cmd = ste_pkg::CMD_TICK;
      else                   cmd = ste_pkg::CMD_WAKE;
      thr = 16'($urandom);
      ky  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if (cmd == ste_pkg::CMD_WAKE && sleepers.size() > 0 && $urandom_range(0, 1) == 1) begin
        j = $urandom_range(0, sleepers.size() - 1);
        if (!sleepers[j].timed) ky = sleepers[j].key;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        sec  = '0;
        nsec = '0;
      end else if (r < 15) begin
        sec  = 14'($urandom);
        nsec = 30'($urandom);
      end else begin
        sec  = 14'($urandom_range(0, 2));
        nsec = 30'($urandom_range(0, 999999999));
      end
      push_request(cmd, thr, ky, sec, nsec, 1'b0, '0);
    end
  endtask

  task automatic report_fail(input string what, input wake_result_t want,
                             input wake_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: exp %0d %h %h %b %b, got %0d %h %h %b %b",
               $realtime, what, want.status, want.thread, want.key, want.timer_active,
               want.last, got.status, got.thread, got.key, got.timer_active, got.last);
  endtask

  // Sample results at each edge and steer tready with random stalls.
  initial begin : result_sink
    int           stall;
    wake_result_t got;
    wake_result_t want;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid_o && m_tready_i) begin
        got = mk_result(ste_pkg::status_e'(m_tuser_o), m_tdata_o[15:0], m_tdata_o[31:16],
                        m_tdata_o[32]);
        got.last = m_tlast_o;
        if (pending_wakes.size() == 0) begin
          report_fail("unexpected result", '0, got);
        end else begin
          want = pending_wakes.pop_front();
          if (got.status != want.status || got.thread != want.thread ||
              got.key != want.key || got.timer_active != want.timer_active ||
              got.last != want.last)
            report_fail("result mismatch", want, got);
        end
      end
      if (stall > 0) begin
        stall--;
        m_tready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0 && idle_len() > 0) begin
        stall = idle_len();
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    step_row_t rw;
    // Empty table, zero-length sleep, one-second sleep and the timer staying on one tick.
    dir_rows.push_back(row(ste_pkg::CMD_TICK,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_WAKE,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_SLEEP, 16'hFFFF, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_WAKE,  16'h0000, 16'hFFFF, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_WOKEN, 16'hFFFF, 16'hFFFF, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_SLEEP, 16'h0001, 16'h0000, 14'd1, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_TICK,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_WOKEN, 16'h0001, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_TICK,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    // Longest sleep, shortest sleep, nanoseconds past their range, a wait on key zero.
    dir_rows.push_back(row(ste_pkg::CMD_SLEEP, 16'h0002, 16'hFFFF, 14'h3FFF, 30'd999999999,
                           1, 1'b1, ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_SLEEP, 16'h0003, 16'h0000, 14'd0, 30'd1, 1, 1'b1,
                           ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_SLEEP, 16'h0004, 16'h0000, 14'd0, 30'h3FFFFFFF, 1, 1'b1,
                           ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_WAIT,  16'h0005, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_TICK,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b0,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_TICK,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b0,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_WAKE,  16'h0000, 16'h0000, 14'd0, 30'd0, 1, 1'b0,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    // Fill the table, hit it when full, then release fifteen waiters in one wake.
    dir_rows.push_back(row(ste_pkg::CMD_WAIT,  16'h0010, 16'h0007, 14'd0, 30'd0, TBL_SLOTS - 1,
                           1'b1, ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_WAIT,  16'h00FF, 16'h0000, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_FULL, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_SLEEP, 16'h0100, 16'h0000, 14'd1, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_FULL, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_WAKE,  16'h0000, 16'h0007, 14'd0, 30'd0, 1, 1'b0,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b0));
    dir_rows.push_back(row(ste_pkg::CMD_WAKE,  16'h0000, 16'h0007, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_NONE, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_WAIT,  16'hAAAA, 16'h5555, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_ACCEPTED, 16'h0000, 16'h0000, 1'b1));
    dir_rows.push_back(row(ste_pkg::CMD_WAKE,  16'h0000, 16'h5555, 14'd0, 30'd0, 1, 1'b1,
                           ste_pkg::STAT_WOKEN, 16'hAAAA, 16'h5555, 1'b1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      for (int r = 0; r < rw.reps; r++)
        push_request(rw.cmd, rw.thread + 16'(r), rw.key, rw.sec, rw.nsec, rw.typed, rw.want);
    end

    // Walk the tick length through its extremes, a zero, random values and back to reset.
    set_tick(40'd1);
    run_random(25);
    set_tick(40'd0);
    run_random(15);
    set_tick(40'hFF_FFFF_FFFF);
    run_random(40);
    set_tick({8'($urandom), 32'($urandom)});
    run_random(30);
    set_tick(40'(64'($urandom_range(1, 1000)) * 64'd1000000000));
    run_random(30);
    set_tick(ste_pkg::TICK_RESET);
    run_random(25);

    drain();
    if (fail_count == 0 && pending_wakes.size() == 0) begin
      $display("sleep_timer_wake_table verification clean");
    end else begin
      $display("sleep_timer_wake_table verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #10_000_000;
    $display("sleep_timer_wake_table verification failed");
    $finish;
  end

endmodule
